// ===== hw/rtl/rtprb_pkg.sv =====
// ----------------------------------------------------------------------------
// rtprb_pkg
// Shared types and constants for the RTP reorder buffer.
// ----------------------------------------------------------------------------
package rtprb_pkg;

    typedef logic [1:0]  kind_t;
    typedef logic [15:0] seq_t;
    typedef logic [31:0] word_t;

    localparam kind_t KIND_HELD     = 2'd0;
    localparam kind_t KIND_RELEASED = 2'd1;
    localparam kind_t KIND_LATE     = 2'd2;
    localparam kind_t KIND_BEYOND   = 2'd3;

    localparam seq_t HALF_SPACE = 16'd32767;

    // results per request and the width of their counter
    localparam int MAX_OUT = 32;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

endpackage

// ===== hw/rtl/rtprb_ifs.sv =====
// ----------------------------------------------------------------------------
// rtprb_ifs
// Valid/ready channels of the RTP reorder buffer: packet in, result out.
// ----------------------------------------------------------------------------
interface rtprb_pkt_if import rtprb_pkg::*; ();
    logic  valid;
    logic  ready;
    seq_t  seq;
    word_t handle;

    modport source (output valid, output seq, output handle, input ready);
    modport sink   (input valid, input seq, input handle, output ready);
endinterface

interface rtprb_res_if import rtprb_pkg::*; ();
    logic  valid;
    logic  ready;
    kind_t kind;
    word_t handle_res;
    word_t ext_seq;
    logic  last;

    modport source (output valid, output kind, output handle_res, output ext_seq,
                    output last, input ready);
    modport sink   (input valid, input kind, input handle_res, input ext_seq,
                    input last, output ready);
endinterface

// ===== hw/rtl/rtp_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// rtp_reorder_buffer
// Unwraps 16-bit RTP sequence numbers, parks packet handles in a window
// memory and releases them in order up to the first gap.
// A held or dropped result is registered from the evaluation state once the
// output is free; a leading release passes the read and emit states.
// A request is taken only in idle, after all results of the last one; each
// release adds a read of the handle memory, then the result register.
// Reset: window empty, unwrap state cleared. A config write before the first
// request sets the expected number and the slot base at once.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer import rtprb_pkg::*; #(
    parameter int WINDOW = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_wdata,
    rtprb_pkt_if.sink       pkt,
    rtprb_res_if.source     res
);

    localparam int IDX_W = $clog2(WINDOW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              started_reg, started_next;
    seq_t              highest_reg, highest_next;
    seq_t              wrap_reg, wrap_next;
    word_t             expected_reg, expected_next;
    logic [IDX_W-1:0]  exp_idx_reg, exp_idx_next;
    logic [WINDOW-1:0] slot_valid_reg, slot_valid_next;
    word_t             ext_reg, ext_next;
    word_t             handle_reg, handle_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    word_t             out_handle_reg, out_handle_next;
    word_t             out_ext_reg, out_ext_next;
    logic              out_last_reg, out_last_next;

    word_t             slot_mem [WINDOW];
    word_t             rd_data_reg;

    logic              accept, out_free;
    seq_t              hs, cyc;
    word_t             off;
    logic              in_win, is_late, dup, exp_valid, store, eval_emit, eval_last;
    logic [IDX_W:0]    idx_sum;
    logic [IDX_W-1:0]  slot_idx, nxt_idx;
    logic              rel_last;

    assign pkt.ready = (state_reg == ST_IDLE);
    assign accept    = pkt.valid && pkt.ready;
    assign out_free  = !out_valid_reg || res.ready;

    assign res.valid      = out_valid_reg;
    assign res.kind       = out_kind_reg;
    assign res.handle_res = out_handle_reg;
    assign res.ext_seq    = out_ext_reg;
    assign res.last       = out_last_reg;

    // sequence unwrap
    always_comb
    begin
        hs           = started_reg ? highest_reg : pkt.seq;
        highest_next = hs;
        wrap_next    = wrap_reg;
        cyc          = wrap_reg;
        if (pkt.seq > hs)
        begin
            if (seq_t'(pkt.seq - hs) > HALF_SPACE)
            begin
                if (wrap_reg != '0)
                begin
                    cyc = wrap_reg - 16'd1;
                end
            end
            else
            begin
                highest_next = pkt.seq;
            end
        end
        else if (seq_t'(hs - pkt.seq) > HALF_SPACE)
        begin
            highest_next = pkt.seq;
            wrap_next    = wrap_reg + 16'd1;
            cyc          = wrap_reg + 16'd1;
        end
    end

    // window test
    always_comb
    begin
        off       = ext_reg - expected_reg;
        in_win    = off < word_t'(WINDOW);
        is_late   = off[31];
        idx_sum   = {1'b0, exp_idx_reg} + {1'b0, off[IDX_W-1:0]};
        slot_idx  = (idx_sum >= (IDX_W+1)'(WINDOW)) ? IDX_W'(idx_sum - (IDX_W+1)'(WINDOW))
                                                    : idx_sum[IDX_W-1:0];
        dup       = slot_valid_reg[slot_idx];
        exp_valid = slot_valid_reg[exp_idx_reg];
        store     = in_win && !dup;
        eval_emit = !store || (!exp_valid && (off[IDX_W-1:0] != '0));
        eval_last = store || !exp_valid;
        nxt_idx   = (exp_idx_reg == IDX_W'(WINDOW - 1)) ? '0 : exp_idx_reg + IDX_W'(1);
        rel_last  = (cnt_reg == CNT_W'(MAX_OUT - 1)) || !slot_valid_reg[nxt_idx];
    end

    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        expected_next   = expected_reg;
        exp_idx_next    = exp_idx_reg;
        slot_valid_next = slot_valid_reg;
        ext_next        = ext_reg;
        handle_next     = handle_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_kind_next   = out_kind_reg;
        out_handle_next = out_handle_reg;
        out_ext_next    = out_ext_reg;
        out_last_next   = out_last_reg;

        // window is empty before the first request, so any slot base will do
        if (cfg_we && !started_reg)
        begin
            expected_next = cfg_wdata;
            exp_idx_next  = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    started_next = 1'b1;
                    ext_next     = {cyc, pkt.seq};
                    handle_next  = pkt.handle;
                    state_next   = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    if (store)
                    begin
                        slot_valid_next[slot_idx] = 1'b1;
                    end
                    if (eval_emit)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = store ? KIND_HELD
                                        : ((in_win || is_late) ? KIND_LATE : KIND_BEYOND);
                        out_handle_next = handle_reg;
                        out_ext_next    = ext_reg;
                        out_last_next   = eval_last;
                        cnt_next        = CNT_W'(1);
                        state_next      = eval_last ? ST_IDLE : ST_RD;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_RELEASED;
                    out_handle_next = rd_data_reg;
                    out_ext_next    = expected_reg;
                    out_last_next   = rel_last;
                    slot_valid_next[exp_idx_reg] = 1'b0;
                    expected_next   = expected_reg + 32'd1;
                    exp_idx_next    = nxt_idx;
                    cnt_next        = cnt_reg + CNT_W'(1);
                    state_next      = rel_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            highest_reg    <= '0;
            wrap_reg       <= '0;
            expected_reg   <= '0;
            exp_idx_reg    <= '0;
            slot_valid_reg <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            if (accept)
            begin
                highest_reg <= highest_next;
                wrap_reg    <= wrap_next;
            end
            expected_reg   <= expected_next;
            exp_idx_reg    <= exp_idx_next;
            slot_valid_reg <= slot_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ext_reg        <= ext_next;
        handle_reg     <= handle_next;
        out_kind_reg   <= out_kind_next;
        out_handle_reg <= out_handle_next;
        out_ext_reg    <= out_ext_next;
        out_last_reg   <= out_last_next;
    end

    // handle memory
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_EVAL) && out_free && store)
        begin
            slot_mem[slot_idx] <= handle_reg;
        end
        rd_data_reg <= slot_mem[exp_idx_reg];
    end

`ifndef SYNTHESIS
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EVAL))
        else $error("accepted request did not enter evaluation");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> slot_valid_reg[exp_idx_reg])
        else $error("release from empty slot");

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_OUT))
        else $error("result count above cap");
`endif

endmodule

// ===== bench/rtp_reorder_buffer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtp_reorder_buffer_tb
// Self-checking bench for the RTP reorder buffer. It starts with a short
// table of packets: the first request, unwrap at wrap count zero, late,
// duplicate and out-of-window drops, the 16-bit wrap and packets from before
// it. Random traffic follows, mostly shuffled runs from the expected number
// or a reversed full window, mixed with late, far and stray packets. Every
// request is run through a local unwrap and window predictor, and each result
// is compared with the oldest predicted one. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer_tb;
    import rtprb_pkg::*;

    localparam int    WINDOW      = 32;
    localparam int    RAND_ITEMS  = 393;
    localparam int    CFG_SETTLE  = 40;
    localparam int    TAIL_CYCLES = 60;
    localparam int    HOLDOFF_AT  = 60;
    localparam int    HOLDOFF_LEN = 400;
    localparam int    CYCLE_LIMIT = 500000;
    localparam word_t START_SEQ   = 32'd65500;

    typedef enum int {NOISE_LATE, NOISE_BEYOND, NOISE_INSIDE} noise_t;
    typedef enum int {RX_STREAM, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        kind_t kind;
        word_t handle;
        word_t ext;
        logic  last;
    } outcome_t;

    typedef struct packed {
        seq_t  seq;
        word_t handle;
        logic  chk;
        kind_t kind;
        word_t ext;
    } dir_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;

    rtprb_pkt_if pkt ();
    rtprb_res_if res ();

    rtp_reorder_buffer #(
        .WINDOW (WINDOW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pkt       (pkt),
        .res       (res)
    );

    // predictor state
    bit       started            = 1'b0;
    seq_t     hi_seq             = 16'd0;
    seq_t     wraps              = 16'd0;
    word_t    exp_seq            = 32'd0;
    bit       slot_valid [WINDOW];
    word_t    slot_handle [WINDOW];
    outcome_t step_q [$];
    outcome_t outcome_q [$];

    int failures     = 0;
    int results_seen = 0;
    int cycle_cnt    = 0;
    int burst_left   = 0;
    bit holdoff_on   = 1'b0;
    bit holdoff_done = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void note_outcome(input kind_t k, input word_t h, input word_t x);
        outcome_t o;
        o      = '{kind: k, handle: h, ext: x, last: 1'b0};
        step_q = {step_q, o};
    endfunction

    function automatic void reorder_packet(input seq_t s, input word_t h);
        seq_t  cycle;
        word_t ext;
        word_t off;
        int    idx;
        bit    stored;
        stored = 1'b0;
        step_q.delete();
        if (!started)
        begin
            hi_seq  = s;
            started = 1'b1;
        end
        cycle = wraps;
        if (s > hi_seq)
        begin
            if (seq_t'(s - hi_seq) > HALF_SPACE)
            begin
                if (wraps != 16'd0)
                    cycle = wraps - 16'd1;
            end
            else
                hi_seq = s;
        end
        else if (seq_t'(hi_seq - s) > HALF_SPACE)
        begin
            hi_seq = s;
            wraps  = wraps + 16'd1;
            cycle  = wraps;
        end
        ext = {cycle, s};
        off = ext - exp_seq;
        if (off < WINDOW)
        begin
            idx = int'(ext % WINDOW);
            if (slot_valid[idx])
                note_outcome(KIND_LATE, h, ext);
            else
            begin
                slot_valid[idx]  = 1'b1;
                slot_handle[idx] = h;
                stored           = 1'b1;
            end
        end
        else if (off >= 32'h8000_0000)
            note_outcome(KIND_LATE, h, ext);
        else
            note_outcome(KIND_BEYOND, h, ext);
        while (step_q.size() < MAX_OUT)
        begin
            idx = int'(exp_seq % WINDOW);
            if (!slot_valid[idx])
                break;
            note_outcome(KIND_RELEASED, slot_handle[idx], exp_seq);
            slot_valid[idx] = 1'b0;
            exp_seq         = exp_seq + 32'd1;
        end
        if (step_q.size() == 0 && stored)
            note_outcome(KIND_HELD, h, ext);
    endfunction

    // one request; chk replaces the prediction by the typed-in result
    task automatic offer_packet(input seq_t s, input word_t h, input logic chk,
                                input kind_t k, input word_t x);
        int       gap;
        int       j;
        outcome_t o;
        pkt.valid  <= 1'b1;
        pkt.seq    <= s;
        pkt.handle <= h;
        @(posedge clk);
        while (!pkt.ready)
            @(posedge clk);
        reorder_packet(s, h);
        if (chk)
        begin
            step_q.delete();
            note_outcome(k, h, x);
        end
        for (j = 0; j < step_q.size(); j++)
        begin
            o         = step_q[j];
            o.last    = (j == step_q.size() - 1);
            outcome_q = {outcome_q, o};
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 19);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0 && !holdoff_on)
            begin
                pkt.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic await_results();
        pkt.valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_first_expected(input word_t v);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (!started)
            exp_seq = v;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        outcome_t want;
        if (res.valid && res.ready)
        begin
            results_seen++;
            if (outcome_q.size() == 0)
            begin
                $error("unexpected result: kind %0d handle %h ext_seq %h",
                       res.kind, res.handle_res, res.ext_seq);
                failures++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (res.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, res.kind);
                    failures++;
                end
                if (res.handle_res !== want.handle)
                begin
                    $error("handle_res: expected %h, got %h", want.handle, res.handle_res);
                    failures++;
                end
                if (res.ext_seq !== want.ext)
                begin
                    $error("ext_seq: expected %h, got %h", want.ext, res.ext_seq);
                    failures++;
                end
                if (res.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, res.last);
                    failures++;
                end
            end
        end
    end

    // receiver: changing stall patterns, one long hold-off
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       n;
        logic     rdy;
        res.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(8, 80);
            for (n = 0; n < span; n++)
            begin
                if (!holdoff_done && results_seen >= HOLDOFF_AT)
                begin
                    holdoff_on = 1'b1;
                    res.ready <= 1'b0;
                    repeat (HOLDOFF_LEN) @(posedge clk);
                    holdoff_on   = 1'b0;
                    holdoff_done = 1'b1;
                end
                case (mode)
                    RX_STREAM: rdy = 1'b1;
                    RX_COIN:   rdy = $urandom_range(0, 1);
                    RX_MOSTLY: rdy = ($urandom_range(0, 7) != 0);
                    default:   rdy = ((n % 5) < 2);
                endcase
                res.ready <= rdy;
                @(posedge clk);
            end
        end
    end

    // sender
    initial
    begin
        int       i;
        int       j;
        int       t;
        int       k;
        noise_t   pick;
        word_t    ext_pick;
        word_t    tmp;
        word_t    block_q [$];
        dir_row_t dir_tab [17];

        pkt.valid  <= 1'b0;
        pkt.seq    <= 16'd0;
        pkt.handle <= 32'd0;
        for (i = 0; i < WINDOW; i++)
        begin
            slot_valid[i]  = 1'b0;
            slot_handle[i] = 32'd0;
        end

        dir_tab = '{
            '{16'd3,     32'h0000_0000, 1'b1, KIND_LATE,     32'd3},
            '{16'd65505, 32'hFFFF_FFFF, 1'b1, KIND_HELD,     32'd65505},
            '{16'd30000, 32'h1357_9BDF, 1'b1, KIND_LATE,     32'd30000},
            '{16'd60000, 32'h2468_ACE0, 1'b1, KIND_LATE,     32'd60000},
            '{16'd65500, 32'hA5A5_5A5A, 1'b1, KIND_RELEASED, 32'd65500},
            '{16'd65500, 32'h0F0F_F0F0, 1'b1, KIND_LATE,     32'd65500},
            '{16'd65505, 32'h3C3C_C3C3, 1'b1, KIND_LATE,     32'd65505},
            '{16'd65504, 32'h1111_2222, 1'b0, KIND_HELD,     32'd0},
            '{16'd65502, 32'h3333_4444, 1'b0, KIND_HELD,     32'd0},
            '{16'd65503, 32'h5555_6666, 1'b0, KIND_HELD,     32'd0},
            '{16'd65501, 32'h7777_8888, 1'b0, KIND_HELD,     32'd0},
            '{16'd65535, 32'h9999_AAAA, 1'b1, KIND_HELD,     32'd65535},
            '{16'd2,     32'hBBBB_CCCC, 1'b1, KIND_BEYOND,   32'h0001_0002},
            '{16'd0,     32'hDDDD_EEEE, 1'b1, KIND_HELD,     32'h0001_0000},
            '{16'd65520, 32'h8000_0001, 1'b1, KIND_HELD,     32'd65520},
            '{16'd40000, 32'h7FFF_FFFE, 1'b1, KIND_LATE,     32'd40000},
            '{16'd600,   32'h6000_0006, 1'b1, KIND_BEYOND,   32'h0001_0258}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        load_first_expected(32'hFFFF_FFFF);
        load_first_expected(32'h0000_0000);
        load_first_expected(START_SEQ);

        for (i = 0; i < $size(dir_tab); i++)
            offer_packet(dir_tab[i].seq, dir_tab[i].handle, dir_tab[i].chk,
                         dir_tab[i].kind, dir_tab[i].ext);

        await_results();
        load_first_expected($urandom());

        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS / 2)
            begin
                await_results();
                load_first_expected(32'hFFFF_FFFF);
            end
            // next run starts at the expected number: shuffled, or a full
            // window in reverse so that the last request drains it
            if (block_q.size() == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    for (j = WINDOW - 1; j >= 0; j--)
                        block_q = {block_q, exp_seq + word_t'(j)};
                end
                else
                begin
                    k = $urandom_range(1, 12);
                    for (j = 0; j < k; j++)
                        block_q = {block_q, exp_seq + word_t'(j)};
                    for (j = k - 1; j > 0; j--)
                    begin
                        t          = $urandom_range(0, j);
                        tmp        = block_q[j];
                        block_q[j] = block_q[t];
                        block_q[t] = tmp;
                    end
                end
            end
            if ($urandom_range(0, 99) < 15)
            begin
                pick = noise_t'($urandom_range(0, 2));
                case (pick)
                    NOISE_LATE:   ext_pick = exp_seq - 32'd1 - $urandom_range(0, 200);
                    NOISE_BEYOND: ext_pick = exp_seq + WINDOW + $urandom_range(0, 300);
                    default:      ext_pick = exp_seq + $urandom_range(0, WINDOW - 1);
                endcase
            end
            else
                ext_pick = block_q.pop_front();
            offer_packet(ext_pick[15:0], $urandom(), 1'b0, KIND_HELD, 32'd0);
        end

        await_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
